>>> hdl/spll_pkg.sv
package spll_pkg;

	localparam int POOL_SLOTS       = 16;
	localparam int PAYLOAD_BITS_DEF = 64;
	localparam int SLOT_W           = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
	localparam int LINK_W           = $clog2(POOL_SLOTS + 1);
	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_SLOTS);

	typedef enum logic [1:0] {
		MODE_PUSH   = 2'd0,
		MODE_INSERT = 2'd1,
		MODE_REMOVE = 2'd2,
		MODE_NOP    = 2'd3
	} op_mode_t;

	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_FULL     = 2'd1,
		STS_EMPTY    = 2'd2,
		STS_NOT_USED = 2'd3
	} op_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_INS_FIN,
		S_RM_LINK,
		S_RM_FIN
	} ctrl_state_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [3:0]  target_slot;
		logic [63:0] payload;
	} req_t;

	typedef struct packed {
		logic [3:0] slot_used;
		logic [1:0] status;
		logic [4:0] live_count;
		logic [4:0] head_slot;
		logic [4:0] tail_slot;
	} rsp_t;

	typedef struct packed {
		logic cap_req;
		logic ins_start;
		logic ins_finish;
		logic rm_start;
		logic rm_link;
		logic rm_finish;
		logic resp_only;
	} dp_cmd_t;

	typedef struct packed {
		logic ins_ok;
		logic rm_ok;
		logic out_free;
	} dp_sts_t;

endpackage

>>> hdl/spll_ram.sv
module spll_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/spll_ctrl.sv
module spll_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  spll_pkg::dp_sts_t sts,
	output spll_pkg::dp_cmd_t cmd
);

	import spll_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (sts.ins_ok) state_d = S_INS_FIN;
				else if (sts.rm_ok) state_d = S_RM_LINK;
				else if (sts.out_free) state_d = S_IDLE;
			end
			S_INS_FIN: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			S_RM_LINK: begin
				state_d = S_RM_FIN;
			end
			S_RM_FIN: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				req_stall   = 1'b0;
				cmd.cap_req = req_valid;
			end
			S_EXEC: begin
				cmd.ins_start = sts.ins_ok;
				cmd.rm_start  = !sts.ins_ok && sts.rm_ok;
				cmd.resp_only = !sts.ins_ok && !sts.rm_ok && sts.out_free;
			end
			S_INS_FIN: cmd.ins_finish = sts.out_free;
			S_RM_LINK: cmd.rm_link    = 1'b1;
			S_RM_FIN:  cmd.rm_finish  = sts.out_free;
			default: ;
		endcase
	end

endmodule

>>> hdl/spll_dp.sv
module spll_dp #(
	parameter int PAYLOAD_BITS = spll_pkg::PAYLOAD_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  spll_pkg::req_t    req,
	input  spll_pkg::dp_cmd_t cmd,
	output spll_pkg::dp_sts_t sts,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output spll_pkg::rsp_t    rsp
);

	import spll_pkg::*;

	req_t                    req_q;
	logic [LINK_W-1:0]       fh_q, ft_q, dh_q, dt_q, cnt_q;
	logic [LINK_W-1:0]       fh_d, ft_d, dh_d, dt_d, cnt_d;
	logic [POOL_SLOTS-1:0]   in_use_q, in_use_d;
	logic [POOL_SLOTS-1:0]   nv_q;
	logic                    out_valid_q;
	rsp_t                    out_q;
	rsp_t                    out_d;
	logic                    load_out;

	op_mode_t                mode;
	logic                    is_ins, front, full, empty, tgt_in_pool;
	logic [SLOT_W-1:0]       s_idx, x_idx;

	logic                    nx_we, nx_re;
	logic [SLOT_W-1:0]       nx_waddr, nx_raddr;
	logic [LINK_W-1:0]       nx_wdata, nx_rdata;
	logic [SLOT_W-1:0]       nx_raddr_q;
	logic                    nx_rvld_q;
	logic [LINK_W-1:0]       nx_val;

	logic                    pv_we, pv_re;
	logic [SLOT_W-1:0]       pv_waddr, pv_raddr;
	logic [LINK_W-1:0]       pv_wdata, pv_rdata;

	assign mode        = op_mode_t'(req_q.mode);
	assign is_ins      = (mode == MODE_PUSH) || (mode == MODE_INSERT);
	assign front       = (mode == MODE_INSERT);
	assign empty       = (dh_q == NULL_LINK);
	assign full        = (cnt_q == LINK_W'(POOL_SLOTS)) || (fh_q == NULL_LINK);
	assign tgt_in_pool = (32'(req_q.target_slot) < POOL_SLOTS);
	assign s_idx       = fh_q[SLOT_W-1:0];
	assign x_idx       = req_q.target_slot[SLOT_W-1:0];

	assign sts.ins_ok   = is_ins && !full;
	assign sts.rm_ok    = (mode == MODE_REMOVE) && (cnt_q != '0) && tgt_in_pool
		&& in_use_q[x_idx];
	assign sts.out_free = !out_valid_q || !rsp_stall;

	// next link: unwritten entries read as their reset value
	assign nx_val = nx_rvld_q ? nx_rdata : LINK_W'(nx_raddr_q) + LINK_W'(1);

	always_comb begin
		nx_we    = 1'b0;
		nx_waddr = s_idx;
		nx_wdata = NULL_LINK;
		nx_re    = 1'b0;
		nx_raddr = s_idx;
		pv_we    = 1'b0;
		pv_waddr = s_idx;
		pv_wdata = NULL_LINK;
		pv_re    = 1'b0;
		pv_raddr = x_idx;
		if (cmd.ins_start) begin
			nx_re    = 1'b1;
			nx_raddr = s_idx;
			nx_we    = !empty && !front;
			nx_waddr = dt_q[SLOT_W-1:0];
			nx_wdata = fh_q;
			pv_we    = 1'b1;
			pv_waddr = s_idx;
			pv_wdata = (front || empty) ? NULL_LINK : dt_q;
		end
		if (cmd.ins_finish) begin
			nx_we    = 1'b1;
			nx_waddr = s_idx;
			nx_wdata = (front && !empty) ? dh_q : NULL_LINK;
			pv_we    = front && !empty;
			pv_waddr = dh_q[SLOT_W-1:0];
			pv_wdata = fh_q;
		end
		if (cmd.rm_start) begin
			nx_re    = 1'b1;
			nx_raddr = x_idx;
			pv_re    = 1'b1;
			pv_raddr = x_idx;
		end
		if (cmd.rm_link) begin
			nx_we    = (pv_rdata != NULL_LINK);
			nx_waddr = pv_rdata[SLOT_W-1:0];
			nx_wdata = nx_val;
			pv_we    = (nx_val != NULL_LINK);
			pv_waddr = nx_val[SLOT_W-1:0];
			pv_wdata = pv_rdata;
		end
		if (cmd.rm_finish) begin
			nx_we    = (ft_q != NULL_LINK);
			nx_waddr = ft_q[SLOT_W-1:0];
			nx_wdata = LINK_W'(x_idx);
		end
	end

	always_comb begin
		fh_d     = fh_q;
		ft_d     = ft_q;
		dh_d     = dh_q;
		dt_d     = dt_q;
		cnt_d    = cnt_q;
		in_use_d = in_use_q;
		if (cmd.ins_finish) begin
			if (fh_q == ft_q) begin
				fh_d = NULL_LINK;
				ft_d = NULL_LINK;
			end else begin
				fh_d = nx_val;
			end
			if (empty) begin
				dh_d = fh_q;
				dt_d = fh_q;
			end else if (front) begin
				dh_d = fh_q;
			end else begin
				dt_d = fh_q;
			end
			in_use_d[s_idx] = 1'b1;
			cnt_d           = cnt_q + LINK_W'(1);
		end
		if (cmd.rm_link) begin
			if (pv_rdata == NULL_LINK) dh_d = nx_val;
			if (nx_val == NULL_LINK) dt_d = pv_rdata;
		end
		if (cmd.rm_finish) begin
			if (ft_q == NULL_LINK) fh_d = LINK_W'(x_idx);
			ft_d            = LINK_W'(x_idx);
			in_use_d[x_idx] = 1'b0;
			cnt_d           = cnt_q - LINK_W'(1);
		end
	end

	assign load_out = cmd.ins_finish || cmd.rm_finish || cmd.resp_only;

	always_comb begin
		out_d            = '0;
		out_d.live_count = 5'(cnt_d);
		out_d.head_slot  = 5'(dh_d);
		out_d.tail_slot  = 5'(dt_d);
		out_d.status     = STS_OK;
		if (cmd.ins_finish) begin
			out_d.slot_used = 4'(s_idx);
		end else if (cmd.rm_finish) begin
			out_d.slot_used = req_q.target_slot;
		end else if (is_ins) begin
			out_d.status = STS_FULL;
		end else if (mode == MODE_REMOVE) begin
			out_d.slot_used = req_q.target_slot;
			out_d.status    = (cnt_q == '0) ? STS_EMPTY : STS_NOT_USED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fh_q        <= '0;
			ft_q        <= LINK_W'(POOL_SLOTS - 1);
			dh_q        <= NULL_LINK;
			dt_q        <= NULL_LINK;
			cnt_q       <= '0;
			in_use_q    <= '0;
			nv_q        <= '0;
			nx_rvld_q   <= 1'b0;
			nx_raddr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			fh_q     <= fh_d;
			ft_q     <= ft_d;
			dh_q     <= dh_d;
			dt_q     <= dt_d;
			cnt_q    <= cnt_d;
			in_use_q <= in_use_d;
			if (nx_we) nv_q[nx_waddr] <= 1'b1;
			if (nx_re) begin
				nx_rvld_q  <= nv_q[nx_raddr];
				nx_raddr_q <= nx_raddr;
			end
			if (load_out) out_valid_q <= 1'b1;
			else if (!rsp_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_req) req_q <= req;
		if (load_out) out_q <= out_d;
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	spll_ram #(
		.WIDTH(LINK_W),
		.DEPTH(POOL_SLOTS)
	) u_next_ram (
		.clk  (clk),
		.we   (nx_we),
		.waddr(nx_waddr),
		.wdata(nx_wdata),
		.re   (nx_re),
		.raddr(nx_raddr),
		.rdata(nx_rdata)
	);

	spll_ram #(
		.WIDTH(LINK_W),
		.DEPTH(POOL_SLOTS)
	) u_prev_ram (
		.clk  (clk),
		.we   (pv_we),
		.waddr(pv_waddr),
		.wdata(pv_wdata),
		.re   (pv_re),
		.raddr(pv_raddr),
		.rdata(pv_rdata)
	);

	spll_ram #(
		.WIDTH(PAYLOAD_BITS),
		.DEPTH(POOL_SLOTS)
	) u_payload_ram (
		.clk  (clk),
		.we   (cmd.ins_start),
		.waddr(s_idx),
		.wdata(req_q.payload[PAYLOAD_BITS-1:0]),
		.re   (1'b0),
		.raddr(s_idx),
		.rdata()
	);

endmodule

>>> hdl/slot_pool_linked_list_top.sv
// Insert steps through the exec and insert-finish states; remove through exec,
// remove-link and remove-finish; rejected or no-op requests only through exec.
// One request in flight; the next is taken the cycle after its result is registered,
// so requests never overlap, and a finish step waits while a held result is stalled.
// Steps come from the registered link reads and the single write port per link RAM.
// Reset restores the initial free chain at once via per-slot link valid bits; no sweep.
module slot_pool_linked_list_top #(
	parameter int PAYLOAD_BITS = spll_pkg::PAYLOAD_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  spll_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output spll_pkg::rsp_t rsp
);

	import spll_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	spll_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	spll_dp #(
		.PAYLOAD_BITS(PAYLOAD_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.sts      (sts),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule

>>> test/slot_pool_linked_list_checker.sv
module slot_pool_linked_list_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	input  logic                            req_stall,
	input  spll_pkg::req_t                  req,
	input  logic                            rsp_valid,
	input  logic                            rsp_stall,
	input  spll_pkg::rsp_t                  rsp,
	output int                              fail_count,
	output int                              outstanding,
	output logic [spll_pkg::POOL_SLOTS-1:0] live_mask
);
	timeunit 1ns;
	timeprecision 1ps;
	import spll_pkg::*;

	logic [LINK_W-1:0]     nxt [POOL_SLOTS];
	logic [LINK_W-1:0]     prv [POOL_SLOTS];
	logic [POOL_SLOTS-1:0] busy;
	logic [LINK_W-1:0]     data_head, data_tail, free_head, free_tail;
	logic [LINK_W-1:0]     used;
	rsp_t                  rsp_due [$];
	int                    errs = 0;

	assign fail_count = errs;

	function automatic void reset_pool();
		for (int i = 0; i < POOL_SLOTS; i++) begin
			nxt[i] = LINK_W'(i + 1);
			prv[i] = (i == 0) ? NULL_LINK : LINK_W'(i - 1);
		end
		busy      = '0;
		data_head = NULL_LINK;
		data_tail = NULL_LINK;
		free_head = '0;
		free_tail = LINK_W'(POOL_SLOTS - 1);
		used      = '0;
	endfunction

	function automatic rsp_t apply_request(req_t r);
		rsp_t              o;
		logic [LINK_W-1:0] s, t, p, n;
		o = '0;
		case (op_mode_t'(r.mode)) inside
			MODE_PUSH, MODE_INSERT: begin
				s = free_head;
				if (used == POOL_SLOTS || s == NULL_LINK) begin
					o.status = STS_FULL;
				end else begin
					free_head = nxt[s];
					if (free_head == NULL_LINK)
						free_tail = NULL_LINK;
					else
						prv[free_head] = NULL_LINK;
					if (data_head == NULL_LINK) begin
						nxt[s]    = NULL_LINK;
						prv[s]    = NULL_LINK;
						data_head = s;
						data_tail = s;
					end else if (op_mode_t'(r.mode) == MODE_INSERT) begin
						prv[s]         = NULL_LINK;
						nxt[s]         = data_head;
						prv[data_head] = s;
						data_head      = s;
					end else begin
						nxt[s]         = NULL_LINK;
						prv[s]         = data_tail;
						nxt[data_tail] = s;
						data_tail      = s;
					end
					busy[s]     = 1'b1;
					used        = used + 1'b1;
					o.slot_used = s[SLOT_W-1:0];
					o.status    = STS_OK;
				end
			end
			MODE_REMOVE: begin
				t = LINK_W'(r.target_slot);
				o.slot_used = r.target_slot;
				if (used == 0) begin
					o.status = STS_EMPTY;
				end else if (!busy[t]) begin
					o.status = STS_NOT_USED;
				end else begin
					p = prv[t];
					n = nxt[t];
					if (p == NULL_LINK)
						data_head = n;
					else
						nxt[p] = n;
					if (n == NULL_LINK)
						data_tail = p;
					else
						prv[n] = p;
					// freed slot goes to the free tail
					nxt[t] = NULL_LINK;
					if (free_tail == NULL_LINK) begin
						prv[t]    = NULL_LINK;
						free_head = t;
					end else begin
						nxt[free_tail] = t;
						prv[t]         = free_tail;
					end
					free_tail = t;
					busy[t]   = 1'b0;
					used      = used - 1'b1;
					o.status  = STS_OK;
				end
			end
			default: o.status = STS_OK;
		endcase
		o.live_count = used;
		o.head_slot  = data_head;
		o.tail_slot  = data_tail;
		return o;
	endfunction

	task automatic compare_field(string name, logic [4:0] want, logic [4:0] got);
		if (want !== got) begin
			errs++;
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			reset_pool();
			rsp_due.delete();
			outstanding <= 0;
			live_mask   <= '0;
		end else begin
			// compare before queuing so a same-edge request is never matched
			if (rsp_valid && !rsp_stall) begin
				if (rsp_due.size() == 0) begin
					errs++;
					$display("%0t: result with no request waiting, expected none got %h",
						$time, rsp);
				end else begin
					want = rsp_due.pop_front();
					compare_field("slot_used", 5'(want.slot_used), 5'(rsp.slot_used));
					compare_field("status", 5'(want.status), 5'(rsp.status));
					compare_field("live_count", want.live_count, rsp.live_count);
					compare_field("head_slot", want.head_slot, rsp.head_slot);
					compare_field("tail_slot", want.tail_slot, rsp.tail_slot);
				end
			end
			if (req_valid && !req_stall)
				rsp_due.push_back(apply_request(req));
			outstanding <= rsp_due.size();
			live_mask   <= busy;
		end
	end

endmodule

>>> test/slot_pool_linked_list_top_tb.sv
module slot_pool_linked_list_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import spll_pkg::*;

	localparam int CLK_PERIOD  = 8;
	localparam int LONG_HOLD   = 64;
	localparam int CYCLE_LIMIT = 200000;

	logic                  clk;
	logic                  arst_n;
	logic                  req_valid;
	logic                  req_stall;
	req_t                  req;
	logic                  rsp_valid;
	logic                  rsp_stall;
	rsp_t                  rsp;
	int                    fails;
	int                    outstanding;
	logic [POOL_SLOTS-1:0] live_mask;
	bit                    calm;
	bit                    want_hold;
	bit                    hold_taken;
	int                    cycles;

	slot_pool_linked_list_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	slot_pool_linked_list_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.fail_count  (fails),
		.outstanding (outstanding),
		.live_mask   (live_mask)
	);

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	// result side: random stall bursts, one long hold-off on request
	initial begin
		forever begin
			if (want_hold && !hold_taken) begin
				hold_taken = 1'b1;
				rsp_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				rsp_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	task automatic send(op_mode_t m, logic [3:0] t, logic [63:0] d);
		req_t r;
		r.mode        = m;
		r.target_slot = t;
		r.payload     = d;
		if (!calm && $urandom_range(0, 7) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	initial begin
		int          bias;
		int          roll;
		logic [3:0]  t;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		calm       = 1'b0;
		want_hold  = 1'b0;
		hold_taken = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty pool, no-op, both ends, remove of a free slot
		send(MODE_REMOVE, 4'd5, '1);
		send(MODE_NOP, 4'd15, '1);
		send(MODE_PUSH, 4'd0, '1);
		send(MODE_INSERT, 4'd15, '0);
		send(MODE_REMOVE, 4'd9, 64'h5555_5555_5555_5555);
		send(MODE_REMOVE, 4'd0, '0);
		send(MODE_REMOVE, 4'd1, '0);
		// fill until the free list runs dry, then overflow
		for (int i = 0; i < POOL_SLOTS; i++)
			send((i % 2) ? MODE_INSERT : MODE_PUSH, 4'(i), rand_word());
		send(MODE_INSERT, 4'd0, '1);
		send(MODE_PUSH, 4'd0, 64'hAAAA_AAAA_AAAA_AAAA);
		// free list empty: freed slot becomes both free ends
		send(MODE_REMOVE, 4'd7, '0);
		send(MODE_REMOVE, 4'd7, '0);

		for (int ph = 0; ph < 12; ph++) begin
			bias = $urandom_range(15, 85);
			calm = (ph >= 10) || ($urandom_range(0, 4) == 0);
			if (ph == 4)
				want_hold = 1'b1;
			if (ph == 7)
				drain();
			for (int i = 0; i < 100; i++) begin
				roll = $urandom_range(0, 99);
				if (roll < 3) begin
					send(MODE_NOP, 4'($urandom), rand_word());
				end else if (roll < 3 + bias) begin
					send($urandom_range(0, 1) ? MODE_INSERT : MODE_PUSH,
						4'($urandom), rand_word());
				end else begin
					t = 4'($urandom);
					// mostly aim at a live slot
					if (live_mask != '0 && $urandom_range(0, 4) != 0)
						while (!live_mask[t]) t = t + 1'b1;
					send(MODE_REMOVE, t, rand_word());
				end
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (fails == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> filelist.f
hdl/spll_pkg.sv
hdl/spll_ram.sv
hdl/spll_ctrl.sv
hdl/spll_dp.sv
hdl/slot_pool_linked_list_top.sv
test/slot_pool_linked_list_checker.sv
test/slot_pool_linked_list_top_tb.sv
